[hdl/cfso_pkg.sv]
package cfso_pkg;

    // Command codes carried by the input beat.
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_REQ    = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;

    // Override percentages.
    localparam int unsigned PCT_W = 7;
    localparam logic [PCT_W-1:0] FULL_PCT   = 7'd100;
    localparam logic [PCT_W-1:0] REDUCE_PCT = 7'd50;
    localparam logic [PCT_W-1:0] ZERO_PCT   = 7'd0;

    // Status codes.
    localparam logic [1:0] ST_NORMAL  = 2'd0;
    localparam logic [1:0] ST_STOP    = 2'd1;
    localparam logic [1:0] ST_REDUCE  = 2'd2;
    localparam logic [1:0] ST_CLEARED = 2'd3;

    // Gain of the quadratic band, fed bit by bit into the divider.
    localparam int unsigned GAIN_BITS = 9;
    localparam logic [GAIN_BITS-1:0] GAIN = 9'd400;

    // Result handed back by the arithmetic unit.
    typedef struct packed {
        logic             done;
        logic [PCT_W-1:0] pct;
    } t_calc_stat;

endpackage

[hdl/cfso_ram.sv]
module cfso_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                       i_wdata,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port with registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/cfso_calc.sv]
module cfso_calc #(
    parameter int VALUE_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_mag,
    input  logic [VALUE_BITS-2:0] i_lim,
    output cfso_pkg::t_calc_stat  o_stat
);

    import cfso_pkg::*;

    localparam int LW = VALUE_BITS - 1;
    localparam int PW = 2 * LW;

    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_CHK  = 3'd1;
    localparam logic [2:0] C_MULD = 3'd2;
    localparam logic [2:0] C_MULL = 3'd3;
    localparam logic [2:0] C_DIV  = 3'd4;
    localparam logic [2:0] C_DONE = 3'd5;

    logic [2:0]           r_state, n_state;
    logic [VALUE_BITS-1:0] r_mag;
    logic [LW-1:0]        r_lim;
    logic [LW-1:0]        r_diff, n_diff;
    logic [PW-1:0]        r_num, n_num;
    logic [PW-1:0]        r_den, n_den;
    logic [PW:0]          r_rem, n_rem;
    logic [GAIN_BITS-1:0] r_quo, n_quo;
    logic [3:0]           r_bit, n_bit;
    logic                 r_phase, n_phase;
    logic [PCT_W-1:0]     r_pct, n_pct;

    logic [LW-1:0] mul_x;
    logic [PW-1:0] prod;
    logic [PW:0]   trial;
    logic          ge;
    logic [GAIN_BITS-1:0] quo_base;

    // Shared multiplier: squares the distance first, then the limit.
    assign mul_x = (r_state == C_MULD) ? r_diff : r_lim;
    assign prod  = PW'(mul_x) * PW'(mul_x);

    // Shared compare-subtract: one restoring step against the squared limit.
    assign trial    = r_phase ? (r_rem + {1'b0, r_num}) : {r_rem[PW-1:0], 1'b0};
    assign ge       = (trial >= {1'b0, r_den});
    assign quo_base = r_phase ? r_quo : {r_quo[GAIN_BITS-2:0], 1'b0};

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_diff  = r_diff;
        n_num   = r_num;
        n_den   = r_den;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_bit   = r_bit;
        n_phase = r_phase;
        n_pct   = r_pct;
        case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    n_state = C_CHK;
                end
            end
            C_CHK: begin
                // Above the limit stops; within half the limit runs at full speed.
                if (r_mag > VALUE_BITS'(r_lim)) begin
                    n_pct   = ZERO_PCT;
                    n_state = C_DONE;
                end else if ({r_mag, 1'b0} <= (VALUE_BITS + 1)'(r_lim)) begin
                    n_pct   = FULL_PCT;
                    n_state = C_DONE;
                end else begin
                    n_diff  = r_lim - r_mag[LW-1:0];
                    n_state = C_MULD;
                end
            end
            C_MULD: begin
                n_num   = prod;
                n_state = C_MULL;
            end
            C_MULL: begin
                n_den   = prod;
                n_rem   = '0;
                n_quo   = '0;
                n_bit   = 4'(GAIN_BITS - 1);
                n_phase = 1'b0;
                n_state = C_DIV;
            end
            C_DIV: begin
                n_rem = ge ? (trial - {1'b0, r_den}) : trial;
                n_quo = quo_base + GAIN_BITS'(ge);
                if (!r_phase && GAIN[r_bit]) begin
                    n_phase = 1'b1;
                end else begin
                    n_phase = 1'b0;
                    if (r_bit == 4'd0) begin
                        n_state = C_DONE;
                    end else begin
                        n_bit = r_bit - 4'd1;
                    end
                end
            end
            C_DONE: begin
                n_state = C_IDLE;
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
        // The quotient stays below 100, so its low bits are the result.
        if (r_state == C_DIV && n_state == C_DONE) begin
            n_pct = n_quo[PCT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (r_state == C_IDLE && i_start) begin
            r_mag <= i_mag;
            r_lim <= i_lim;
        end
        r_diff  <= n_diff;
        r_num   <= n_num;
        r_den   <= n_den;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_bit   <= n_bit;
        r_phase <= n_phase;
        r_pct   <= n_pct;
    end

    assign o_stat.done = (r_state == C_DONE);
    assign o_stat.pct  = r_pct;

endmodule

[hdl/contact_force_speed_override_top.sv]
// Contact force speed override. Each input beat either loads a channel's maximum
// limit (which also becomes its active limit), requests a runtime limit (clamped to
// the maximum), or delivers one channel sample. A sample yields 0 above its limit,
// 100 within half of it, and floor(400*((L-|x|)/L)^2) in between; on the beat marked
// last_of_scan the scan minimum goes out with a status (normal, stop, reduce, cleared).
// A sample on an out-of-range channel counts as 100 without the arithmetic; one outside
// the quadratic band is settled by the range check alone, and one inside it passes
// through the shared multiplier (two squarings) and the 12-step serial divider that
// follows it. The input stalls while an item is in work; a finished result waits in
// the output register without holding off the next beat, unless a new scan closes
// before it is taken. Limits read from a channel that was never loaded are undefined.
module contact_force_speed_override_top #(
    parameter int NUM_CHANNELS = 12,
    parameter int VALUE_BITS   = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_cmd,
    input  logic [3:0]                   i_channel,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic                         i_last_of_scan,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [6:0]                   o_override_pct,
    output logic [1:0]                   o_status
);

    import cfso_pkg::*;

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CW = (AW > 4) ? AW : 4;
    localparam int LW = VALUE_BITS - 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_REQ  = 3'd1;
    localparam logic [2:0] S_SAMP = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    // Negative limits count as zero.
    function automatic logic [LW-1:0] limit_of(input logic [VALUE_BITS-1:0] v);
        return v[VALUE_BITS-1] ? '0 : v[LW-1:0];
    endfunction

    function automatic logic [VALUE_BITS-1:0] magnitude(input logic [VALUE_BITS-1:0] v);
        return v[VALUE_BITS-1] ? (~v + 1'b1) : v;
    endfunction

    logic [2:0]            r_state, n_state;
    logic [AW-1:0]         r_addr;
    logic                  r_ok;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_last;
    logic [PCT_W-1:0]      r_pct;
    logic [PCT_W-1:0]      r_scan_min;
    logic                  r_contact;
    logic                  r_out_valid;
    logic [PCT_W-1:0]      r_out_pct;
    logic [1:0]            r_out_status;

    logic          accept;
    logic [CW-1:0] in_ch_ext;
    logic [AW-1:0] in_addr;
    logic          in_ok;
    logic [LW-1:0] in_lim;
    logic [LW-1:0] req_lim;
    logic [LW-1:0] req_min;
    logic [AW-1:0] ram_addr;
    logic          max_we;
    logic          act_we;
    logic [LW-1:0] act_wdata;
    logic [LW-1:0] max_rdata;
    logic [LW-1:0] act_rdata;
    logic          calc_start;
    t_calc_stat    calc_stat;
    logic          out_free;
    logic          fin_go;
    logic [PCT_W-1:0] new_min;

    // Input beat decode.
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign in_ch_ext  = CW'(i_channel);
    assign in_addr    = in_ch_ext[AW-1:0];
    assign in_ok      = (32'(i_channel) < NUM_CHANNELS);
    assign in_lim     = limit_of(i_value);

    // Limit stores share one address: the beat's channel when idle, else the held one.
    assign ram_addr  = (r_state == S_IDLE) ? in_addr : r_addr;
    assign req_lim   = limit_of(r_value);
    assign req_min   = (req_lim < max_rdata) ? req_lim : max_rdata;
    assign max_we    = accept && (i_cmd == CMD_LOAD) && in_ok;
    assign act_we    = max_we || ((r_state == S_REQ) && r_ok);
    assign act_wdata = (r_state == S_REQ) ? req_min : in_lim;

    cfso_ram #(
        .WIDTH (LW),
        .DEPTH (NUM_CHANNELS)
    ) u_max_ram (
        .i_clk   (i_clk),
        .i_we    (max_we),
        .i_addr  (ram_addr),
        .i_wdata (in_lim),
        .o_rdata (max_rdata)
    );

    cfso_ram #(
        .WIDTH (LW),
        .DEPTH (NUM_CHANNELS)
    ) u_act_ram (
        .i_clk   (i_clk),
        .i_we    (act_we),
        .i_addr  (ram_addr),
        .i_wdata (act_wdata),
        .o_rdata (act_rdata)
    );

    // Per-channel override arithmetic.
    assign calc_start = (r_state == S_SAMP) && r_ok;

    cfso_calc #(
        .VALUE_BITS (VALUE_BITS)
    ) u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (calc_start),
        .i_mag   (magnitude(r_value)),
        .i_lim   (act_rdata),
        .o_stat  (calc_stat)
    );

    // A closing sample waits until the output register can take its beat.
    assign out_free = !r_out_valid || !i_out_stall;
    assign fin_go   = (r_state == S_FIN) && (!r_last || out_free);
    assign new_min  = (r_pct < r_scan_min) ? r_pct : r_scan_min;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        CMD_REQ:    n_state = in_ok ? S_REQ : S_IDLE;
                        CMD_SAMPLE: n_state = S_SAMP;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_REQ:  n_state = S_IDLE;
            S_SAMP: n_state = r_ok ? S_WAIT : S_FIN;
            S_WAIT: n_state = calc_stat.done ? S_FIN : S_WAIT;
            S_FIN:  n_state = fin_go ? S_IDLE : S_FIN;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scan_min  <= FULL_PCT;
            r_contact   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // The output register empties on a taken beat unless a closing sample refills it.
            if (fin_go && r_last) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            // Fold the sample into the scan; a closing beat emits and restarts it.
            if (fin_go) begin
                if (r_last) begin
                    r_scan_min   <= FULL_PCT;
                    r_out_pct    <= new_min;
                    if (new_min == ZERO_PCT) begin
                        r_out_status <= ST_STOP;
                        r_contact    <= 1'b1;
                    end else if (new_min < REDUCE_PCT) begin
                        r_out_status <= ST_REDUCE;
                        r_contact    <= 1'b1;
                    end else if (r_contact) begin
                        r_out_status <= ST_CLEARED;
                        r_contact    <= 1'b0;
                    end else begin
                        r_out_status <= ST_NORMAL;
                    end
                end else begin
                    r_scan_min <= new_min;
                end
            end
        end
        // Beat holding registers.
        if (accept) begin
            r_addr  <= in_addr;
            r_ok    <= in_ok;
            r_value <= i_value;
            r_last  <= i_last_of_scan;
        end
        if (r_state == S_SAMP && !r_ok) begin
            r_pct <= FULL_PCT;
        end else if (r_state == S_WAIT && calc_stat.done) begin
            r_pct <= calc_stat.pct;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_override_pct = r_out_pct;
    assign o_status       = r_out_status;

endmodule
